// ===== sv/ppm_pkg.sv =====
// Package for the pulse period rpm meter: widths, constants, register
// indexes and the command and status structs between controller and datapath.
// No dependencies.
package ppm_pkg;

  localparam int TIME_W    = 32;
  localparam int PERIOD_W  = 32;
  localparam int SPEED_W   = 27;
  localparam int MANUAL_W  = 16;
  localparam int PPR_W     = 8;
  localparam int DEN_W     = PERIOD_W + PPR_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [SPEED_W-1:0] SPEED_SCALE = SPEED_W'(120000000);
  localparam logic [PPR_W-1:0]   PPR_RESET   = PPR_W'(36);

  // One quotient bit per step of the serial divider.
  localparam int DIV_STEPS = SPEED_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MODE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MANUAL_SPEED   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_REV = CFG_IDX_W'(2);

  typedef struct packed {
    logic capture;
    logic eval;
    logic mul_load;
    logic div_step;
    logic speed_save;
    logic out_load;
  } ppm_cmd_t;

  typedef struct packed {
    logic need_div;
  } ppm_sts_t;

endpackage

// ===== sv/ppm_if.sv =====
// Handshake interfaces for the edge input channel and the result channel.
// Depends on ppm_pkg for the field widths.
interface ppm_in_if import ppm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] edge_time_us;

  modport source (output valid, output edge_time_us, input ready);
  modport sink (input valid, input edge_time_us, output ready);
endinterface

interface ppm_out_if import ppm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SPEED_W-1:0]  speed_rpm;
  logic [PERIOD_W-1:0] period_us;
  logic                edge_accepted;

  modport source (output valid, output speed_rpm, output period_us,
                  output edge_accepted, input ready);
  modport sink (input valid, input speed_rpm, input period_us,
                input edge_accepted, output ready);
endinterface

// ===== sv/ppm_ctrl.sv =====
// Controller state machine of the rpm meter: sequences capture, edge
// evaluation, the serial division and the result register. Uses ppm_pkg.
module ppm_ctrl import ppm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  ppm_sts_t sts,
  output ppm_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_SAVE = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.need_div ? S_MUL : S_OUT;
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_SAVE;
        end
      end
      S_SAVE: begin
        cmd.speed_save = 1'b1;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        // The result register frees up when the last result is transferred.
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/ppm_dpath.sv =====
// Datapath of the rpm meter: configuration registers, edge blanking and
// pairing state, multiplier, restoring divider and result register. Uses ppm_pkg.
module ppm_dpath import ppm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic [TIME_W-1:0]    in_time,
  input  ppm_cmd_t             cmd,
  output ppm_sts_t             sts,
  output logic [SPEED_W-1:0]   out_speed,
  output logic [PERIOD_W-1:0]  out_period,
  output logic                 out_accepted
);

  logic                source_mode_r;
  logic [MANUAL_W-1:0] manual_speed_r;
  logic [PPR_W-1:0]    ppr_r;

  logic [TIME_W-1:0]   time_r;
  logic [TIME_W-1:0]   last_time_r;
  logic [TIME_W-1:0]   pair_start_r;
  logic [PERIOD_W-1:0] period_r;
  logic                pair_open_r;
  logic [SPEED_W-1:0]  meas_speed_r;
  logic                accepted_r;

  logic [DEN_W-1:0]    den_r;
  logic [SPEED_W-1:0]  rem_r;
  logic [SPEED_W-1:0]  quo_r;

  logic [SPEED_W-1:0]  out_speed_r;
  logic [PERIOD_W-1:0] out_period_r;
  logic                out_accepted_r;

  logic [TIME_W-1:0]   delta;
  logic                accepted;
  logic [PERIOD_W-1:0] period_nxt;
  logic [PPR_W-1:0]    ppr_eff;
  logic [SPEED_W:0]    trial;
  logic [DEN_W-1:0]    diff;
  logic                fits;

  // An edge counts when the time since the last accepted edge exceeds
  // half the stored period.
  assign delta    = time_r - last_time_r;
  assign accepted = delta > (period_r >> 1);

  always_comb begin
    period_nxt = period_r;
    if (accepted && pair_open_r && (pair_start_r < time_r)) begin
      period_nxt = PERIOD_W'(time_r - pair_start_r);
    end
  end

  assign sts.need_div = accepted && (period_nxt != '0);

  assign ppr_eff = (ppr_r == '0) ? PPR_W'(1) : ppr_r;
  assign trial   = {rem_r, quo_r[SPEED_W-1]};
  assign diff    = DEN_W'(trial) - den_r;
  assign fits    = DEN_W'(trial) >= den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_mode_r  <= 1'b0;
      manual_speed_r <= '0;
      ppr_r          <= PPR_RESET;
      last_time_r    <= '0;
      pair_start_r   <= '0;
      period_r       <= '0;
      pair_open_r    <= 1'b0;
      meas_speed_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SOURCE_MODE:    source_mode_r  <= cfg_data[0];
          REG_MANUAL_SPEED:   manual_speed_r <= cfg_data[MANUAL_W-1:0];
          REG_PULSES_PER_REV: ppr_r          <= cfg_data[PPR_W-1:0];
          default: ;
        endcase
      end
      if (cmd.eval && accepted) begin
        last_time_r <= time_r;
        period_r    <= period_nxt;
        pair_open_r <= !pair_open_r;
        if (!pair_open_r) begin
          pair_start_r <= time_r;
        end
      end
      if (cmd.speed_save) begin
        meas_speed_r <= quo_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      time_r <= in_time;
    end
    if (cmd.eval) begin
      accepted_r <= accepted;
    end
    if (cmd.mul_load) begin
      den_r <= DEN_W'(ppr_eff) * DEN_W'(period_r);
      rem_r <= '0;
      quo_r <= SPEED_SCALE;
    end else if (cmd.div_step) begin
      // The dividend shifts out of quo_r as quotient bits shift in.
      rem_r <= fits ? diff[SPEED_W-1:0] : trial[SPEED_W-1:0];
      quo_r <= {quo_r[SPEED_W-2:0], fits};
    end
    if (cmd.out_load) begin
      out_speed_r    <= source_mode_r ? SPEED_W'(manual_speed_r) : meas_speed_r;
      out_period_r   <= period_r;
      out_accepted_r <= accepted_r;
    end
  end

  assign out_speed    = out_speed_r;
  assign out_period   = out_period_r;
  assign out_accepted = out_accepted_r;

endmodule

// ===== sv/pulse_period_rpm_meter_core.sv =====
// Top level of the pulse period rpm meter: joins controller and datapath.
// Depends on ppm_pkg, ppm_if, ppm_ctrl and ppm_dpath.
//
// Usage: each rising tachometer edge is offered on in_if as one transfer
// carrying its microsecond timestamp. For every edge exactly one result is
// transferred on out_if: the speed in rpm (measured, or the manual value in
// manual mode), the stored period and whether the edge passed blanking.
// Configuration is to be written by the user through cfg_we, cfg_index and
// cfg_data while the block is idle; the block itself does not enforce this.
// An unknown index is ignored. An accepted edge whose period, new or stored,
// is nonzero runs a 27-step restoring divider before its result is loaded;
// any other edge skips the divider. A new edge is taken only after the result
// of the previous edge has entered the output register and the block is idle.
// Reset clears the configuration to its defaults (36 pulses per revolution)
// and the measurement state to zero. When the receiver stalls, the result
// waits in the output register while the next edge is accepted and worked
// on; that edge's result waits until the held one has been transferred.
module pulse_period_rpm_meter_core import ppm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  ppm_in_if.sink               in_if,
  ppm_out_if.source            out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  ppm_cmd_t cmd;
  ppm_sts_t sts;

  ppm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ppm_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_time      (in_if.edge_time_us),
    .cmd          (cmd),
    .sts          (sts),
    .out_speed    (out_if.speed_rpm),
    .out_period   (out_if.period_us),
    .out_accepted (out_if.edge_accepted)
  );

endmodule
